[hw/rtl/mfe_pkg.sv]
`timescale 1ns / 1ps
package mfe_pkg;

   localparam int SIGNAL_COUNT = 11;
   localparam int MAX_SPANS = 4;
   localparam int SPAN_COUNT_DEFAULT = 4;
   localparam int STATE_FRAC_BITS = 32;
   localparam int CSR_COUNT = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int ALPHA_SEL_W = $clog2(MAX_SPANS);
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   typedef logic [3:0] sig_index_type;

   localparam sig_index_type SIG_TEMP        = 4'd0;
   localparam sig_index_type SIG_VOLT_D      = 4'd1;
   localparam sig_index_type SIG_VOLT_Q      = 4'd2;
   localparam sig_index_type SIG_SPEED       = 4'd3;
   localparam sig_index_type SIG_CURR_D      = 4'd4;
   localparam sig_index_type SIG_CURR_Q      = 4'd5;
   localparam sig_index_type SIG_VOLT_MAG    = 4'd6;
   localparam sig_index_type SIG_CURR_MAG    = 4'd7;
   localparam sig_index_type SIG_POWER       = 4'd8;
   localparam sig_index_type SIG_SPEED_CURR  = 4'd9;
   localparam sig_index_type SIG_SPEED_POWER = 4'd10;

   localparam logic [31:0] ALPHA_RESET [MAX_SPANS] = '{
      32'd1301308, 32'd511275, 32'd270115, 32'd181218
   };

   localparam logic [32:0] W_ONE = 33'h1_0000_0000;
   localparam logic signed [63:0] STATE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] temperature;
      logic signed [31:0] voltage_d;
      logic signed [31:0] voltage_q;
      logic signed [31:0] speed_rpm;
      logic signed [31:0] current_d;
      logic signed [31:0] current_q;
      logic [5:0]         valid_mask;
   } req_item_type;

   typedef struct packed {
      sig_index_type      sig_num;
      logic signed [63:0] raw_value;
      logic signed [63:0] mean_span0;
      logic signed [63:0] mean_span1;
      logic signed [63:0] mean_span2;
      logic signed [63:0] mean_span3;
      logic               last_of_sample;
   } rsp_item_type;

   typedef struct packed {
      sig_index_type      index;
      logic signed [63:0] value;
      logic               valid;
   } sig_item_type;

   typedef struct packed {
      logic signed [63:0] mean;
      logic [32:0]        weight;
   } span_entry_type;

   typedef enum logic [2:0] {
      F_IDLE, F_RAW, F_SQ, F_ROOT, F_MUL, F_MFIN, F_HALF, F_EMIT
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_READ, B_LOAD, B_DECAY, B_DIV, B_MUL0, B_MUL1, B_ADD, B_PUSH
   } back_state_type;

endpackage

[hw/rtl/motor_feature_ewma_bank_core.sv]
// front part: per sample, two 32-step square roots and three products; back part: one
// signal and span at a time, with a shared 33-step divider for the span update of each
// started span receiving a valid value; a new sample is taken only once the front is idle
// reset: synchronous, marks all averages unstarted, empties queues, clears state; alphas return to defaults
`timescale 1ns / 1ps
module motor_feature_ewma_bank_core #(
   parameter int SPAN_COUNT = mfe_pkg::SPAN_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  mfe_pkg::req_item_type             req_item,
   output logic                              empty,
   input  logic                              pop,
   output mfe_pkg::rsp_item_type             rsp_item,
   input  logic                              csr_write_en,
   input  logic [mfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_wdata
);
   import mfe_pkg::*;

   logic [31:0] alpha_ff [MAX_SPANS];
   logic mid_full, mid_push, mid_empty, mid_pop, out_full, out_push;
   sig_item_type mid_in_item, mid_out_item;
   rsp_item_type out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_write_en && (csr_index < CSR_INDEX_W'(CSR_COUNT))) begin
         alpha_ff[csr_index[ALPHA_SEL_W-1:0]] <= csr_wdata;
      end
   end

   mfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_item (mid_in_item)
   );

   mfe_fifo #(
      .DEPTH     (MID_DEPTH),
      .item_type (sig_item_type)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_item (mid_in_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_item  (mid_out_item),
      .empty     (mid_empty)
   );

   mfe_back #(
      .SPAN_COUNT (SPAN_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .alpha     (alpha_ff),
      .mid_empty (mid_empty),
      .mid_item  (mid_out_item),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   mfe_fifo #(
      .DEPTH     (OUT_DEPTH),
      .item_type (rsp_item_type)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (pop),
      .pop_item  (rsp_item),
      .empty     (empty)
   );

endmodule

[hw/rtl/mfe_fifo.sv]
`timescale 1ns / 1ps
module mfe_fifo #(
   parameter int DEPTH = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = store_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? PTR_W'(wr_ff + PTR_W'(1)) : wr_ff;
      rd_in = do_pop ? PTR_W'(rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = CNT_W'(cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_item;
      end
   end

endmodule

[hw/rtl/mfe_front.sv]
`timescale 1ns / 1ps
module mfe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  mfe_pkg::req_item_type req_item,
   input  logic                  mid_full,
   output logic                  mid_push,
   output mfe_pkg::sig_item_type mid_item
);
   import mfe_pkg::*;

   localparam int IN_SHIFT = STATE_FRAC_BITS - 16;

   function automatic logic signed [31:0] raw_field(req_item_type it, sig_index_type idx);
      logic signed [31:0] r;
      case (idx)
         SIG_TEMP:   r = it.temperature;
         SIG_VOLT_D: r = it.voltage_d;
         SIG_VOLT_Q: r = it.voltage_q;
         SIG_SPEED:  r = it.speed_rpm;
         SIG_CURR_D: r = it.current_d;
         default:    r = it.current_q;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] needs_mask(sig_index_type idx);
      logic [5:0] m;
      case (idx)
         SIG_TEMP:        m = 6'h01;
         SIG_VOLT_D:      m = 6'h02;
         SIG_VOLT_Q:      m = 6'h04;
         SIG_SPEED:       m = 6'h08;
         SIG_CURR_D:      m = 6'h10;
         SIG_CURR_Q:      m = 6'h20;
         SIG_VOLT_MAG:    m = 6'h06;
         SIG_CURR_MAG:    m = 6'h30;
         SIG_POWER:       m = 6'h36;
         SIG_SPEED_CURR:  m = 6'h38;
         default:         m = 6'h3E;
      endcase
      return m;
   endfunction

   function automatic logic signed [63:0] to_state(logic signed [31:0] x);
      logic signed [63:0] t;
      t = 64'(x);
      return t <<< IN_SHIFT;
   endfunction

   function automatic logic [31:0] mag32(logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   front_state_type state_ff, state_in;
   req_item_type item_ff, item_in;
   sig_index_type sig_ff, sig_in;
   logic [5:0] cnt_ff, cnt_in;
   logic signed [63:0] val_ff, val_in, s6_ff, s6_in, s7_ff, s7_in, s8_ff, s8_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in;
   logic neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p, root_t, mag_m;
   logic [127:0] shifted;
   logic signed [63:0] sig3, half, lim, op_a, op_b;
   logic [5:0] need;

   assign mul_p = mul_a * mul_b;
   assign full = (state_ff != F_IDLE);
   assign sig3 = to_state(item_ff.speed_rpm);
   assign need = needs_mask(sig_ff);

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      sig_in = sig_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      s6_in = s6_ff;
      s7_in = s7_ff;
      s8_in = s8_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      pp_in = pp_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      mul_a = '0;
      mul_b = '0;
      root_t = res_ff + bit_ff;
      shifted = acc_ff >> STATE_FRAC_BITS;
      mag_m = '0;
      half = val_ff >>> 1;
      lim = STATE_MAX - half;
      op_a = s6_ff;
      op_b = s7_ff;
      mid_push = 1'b0;
      mid_item.index = sig_ff;
      mid_item.value = val_ff;
      mid_item.valid = ((item_ff.valid_mask & need) == need);
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               item_in = req_item;
               sig_in = SIG_TEMP;
               state_in = F_RAW;
            end
         end
         F_RAW: begin
            mid_item.value = to_state(raw_field(item_ff, sig_ff));
            if (!mid_full) begin
               mid_push = 1'b1;
               cnt_in = '0;
               sig_in = sig_index_type'(sig_ff + 4'd1);
               if (sig_ff == SIG_CURR_Q) begin
                  state_in = F_SQ;
               end
            end
         end
         F_SQ: begin
            // sum of squares of the two axis values
            case (cnt_ff)
               6'd0: begin
                  mul_a = mag32(sig_ff == SIG_VOLT_MAG ? item_ff.voltage_d : item_ff.current_d);
                  mul_b = mul_a;
                  pp_in = mul_p;
                  cnt_in = 6'd1;
               end
               6'd1: begin
                  mul_a = mag32(sig_ff == SIG_VOLT_MAG ? item_ff.voltage_q : item_ff.current_q);
                  mul_b = mul_a;
                  pp_in = mul_p;
                  acc_in = {64'd0, pp_ff};
                  cnt_in = 6'd2;
               end
               default: begin
                  x_in = acc_ff[63:0] + pp_ff;
                  res_in = '0;
                  bit_in = 64'h4000_0000_0000_0000;
                  cnt_in = '0;
                  state_in = F_ROOT;
               end
            endcase
         end
         F_ROOT: begin
            if (x_ff >= root_t) begin
               x_in = x_ff - root_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == 6'd31) begin
               val_in = signed'(res_in << IN_SHIFT);
               if (sig_ff == SIG_VOLT_MAG) begin
                  s6_in = signed'(res_in << IN_SHIFT);
               end else begin
                  s7_in = signed'(res_in << IN_SHIFT);
               end
               state_in = F_EMIT;
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         F_MUL: begin
            // 64x64 magnitude product from four 32x32 partial products
            case (cnt_ff)
               6'd0: begin
                  mul_a = ma_ff[31:0];
                  mul_b = mb_ff[31:0];
               end
               6'd1: begin
                  mul_a = ma_ff[31:0];
                  mul_b = mb_ff[63:32];
               end
               6'd2: begin
                  mul_a = ma_ff[63:32];
                  mul_b = mb_ff[31:0];
               end
               default: begin
                  mul_a = ma_ff[63:32];
                  mul_b = mb_ff[63:32];
               end
            endcase
            pp_in = mul_p;
            case (cnt_ff)
               6'd0:    acc_in = '0;
               6'd1:    acc_in = acc_ff + 128'(pp_ff);
               6'd2:    acc_in = acc_ff + (128'(pp_ff) << 32);
               6'd3:    acc_in = acc_ff + (128'(pp_ff) << 32);
               default: acc_in = acc_ff + (128'(pp_ff) << 64);
            endcase
            if (cnt_ff == 6'd4) begin
               state_in = F_MFIN;
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         F_MFIN: begin
            mag_m = (|shifted[127:63]) ? 64'(STATE_MAX) : shifted[63:0];
            val_in = neg_ff ? -signed'(mag_m) : signed'(mag_m);
            state_in = (sig_ff == SIG_POWER) ? F_HALF : F_EMIT;
         end
         F_HALF: begin
            val_in = (val_ff > lim) ? STATE_MAX : 64'(val_ff + half);
            s8_in = val_in;
            state_in = F_EMIT;
         end
         default: begin
            if (!mid_full) begin
               mid_push = 1'b1;
               cnt_in = '0;
               case (sig_ff)
                  SIG_VOLT_MAG: begin
                     sig_in = SIG_CURR_MAG;
                     state_in = F_SQ;
                  end
                  SIG_CURR_MAG: begin
                     op_a = s6_ff;
                     op_b = s7_ff;
                     sig_in = SIG_POWER;
                     state_in = F_MUL;
                  end
                  SIG_POWER: begin
                     op_a = sig3;
                     op_b = s7_ff;
                     sig_in = SIG_SPEED_CURR;
                     state_in = F_MUL;
                  end
                  SIG_SPEED_CURR: begin
                     op_a = sig3;
                     op_b = s8_ff;
                     sig_in = SIG_SPEED_POWER;
                     state_in = F_MUL;
                  end
                  default: begin
                     state_in = F_IDLE;
                  end
               endcase
               ma_in = mag64(op_a);
               mb_in = mag64(op_b);
               neg_in = op_a[63] ^ op_b[63];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sig_ff <= sig_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      s6_ff <= s6_in;
      s7_ff <= s7_in;
      s8_ff <= s8_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      pp_ff <= pp_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule

[hw/rtl/mfe_back.sv]
`timescale 1ns / 1ps
module mfe_back #(
   parameter int SPAN_COUNT = mfe_pkg::SPAN_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           alpha [mfe_pkg::MAX_SPANS],
   input  logic                  mid_empty,
   input  mfe_pkg::sig_item_type mid_item,
   output logic                  mid_pop,
   input  logic                  out_full,
   output logic                  out_push,
   output mfe_pkg::rsp_item_type out_item
);
   import mfe_pkg::*;

   localparam int DEPTH = SIGNAL_COUNT * SPAN_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SPAN_W = (SPAN_COUNT > 1) ? $clog2(SPAN_COUNT) : 1;

   span_entry_type state_mem [DEPTH];

   back_state_type state_ff, state_in;
   sig_item_type cur_ff, cur_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DEPTH-1:0] started_ff, started_in;
   span_entry_type rd_ff;
   logic [32:0] w_ff, w_in, q_ff, q_in;
   logic [33:0] den_ff, den_in;
   logic [34:0] rem_ff, rem_in;
   logic signed [63:0] m_ff, m_in;
   logic [63:0] d_ff, d_in;
   logic up_ff, up_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [64:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [63:0] mean_ff [SPAN_COUNT];
   logic signed [63:0] mean_in [SPAN_COUNT];

   logic wr_en, span_done, ge;
   span_entry_type wr_data;
   logic [31:0] alpha_cur;
   logic [64:0] decay_p;
   logic [33:0] den_v;
   logic [34:0] trial;
   logic [63:0] step;
   logic signed [63:0] new_m;
   logic signed [63:0] mean_full [MAX_SPANS];

   assign alpha_cur = alpha[ALPHA_SEL_W'(span_ff)];

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      span_in = span_ff;
      addr_in = addr_ff;
      started_in = started_ff;
      w_in = w_ff;
      q_in = q_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      m_in = m_ff;
      d_in = d_ff;
      up_in = up_ff;
      cnt_in = cnt_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      mean_in = mean_ff;
      mid_pop = 1'b0;
      out_push = 1'b0;
      wr_en = 1'b0;
      wr_data.mean = m_ff;
      wr_data.weight = w_ff;
      span_done = 1'b0;
      decay_p = 65'(rd_ff.weight) * 65'(W_ONE - 33'(alpha_cur));
      den_v = 34'(w_ff) + 34'(alpha_cur);
      trial = (cnt_ff == '0) ? rem_ff : (rem_ff << 1);
      ge = (trial >= 35'(den_ff));
      step = 64'(p1_ff + 65'(p0_ff[64:32]));
      new_m = up_ff ? 64'(m_ff + signed'(step)) : 64'(m_ff - signed'(step));
      case (state_ff)
         B_IDLE: begin
            if (!mid_empty && !out_full) begin
               mid_pop = 1'b1;
               cur_in = mid_item;
               span_in = '0;
               addr_in = ADDR_W'(int'(mid_item.index) * SPAN_COUNT);
               for (int k = 0; k < SPAN_COUNT; k++) begin
                  mean_in[k] = '0;
               end
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_LOAD;
         end
         B_LOAD: begin
            if (!started_ff[addr_ff]) begin
               // first valid value seeds the average
               if (cur_ff.valid) begin
                  wr_en = 1'b1;
                  wr_data.mean = cur_ff.value;
                  wr_data.weight = W_ONE;
                  started_in[addr_ff] = 1'b1;
                  mean_in[span_ff] = cur_ff.value;
               end
               span_done = 1'b1;
            end else begin
               m_in = rd_ff.mean;
               w_in = (alpha_cur != '0) ? decay_p[64:32] : rd_ff.weight;
               state_in = B_DECAY;
            end
         end
         B_DECAY: begin
            if (!cur_ff.valid) begin
               wr_en = 1'b1;
               mean_in[span_ff] = m_ff;
               span_done = 1'b1;
            end else begin
               up_in = (cur_ff.value >= m_ff);
               d_in = (cur_ff.value >= m_ff) ? 64'(cur_ff.value - m_ff)
                                             : 64'(m_ff - cur_ff.value);
               den_in = den_v;
               rem_in = 35'(alpha_cur);
               q_in = '0;
               cnt_in = '0;
               if (den_v == '0) begin
                  q_in = W_ONE;
                  state_in = B_MUL0;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            rem_in = ge ? 35'(trial - 35'(den_ff)) : trial;
            q_in = {q_ff[31:0], ge};
            if (cnt_ff == 6'd32) begin
               state_in = B_MUL0;
            end else begin
               cnt_in = 6'(cnt_ff + 6'd1);
            end
         end
         B_MUL0: begin
            p0_in = d_ff[31:0] * q_ff;
            state_in = B_MUL1;
         end
         B_MUL1: begin
            p1_in = d_ff[63:32] * q_ff;
            state_in = B_ADD;
         end
         B_ADD: begin
            wr_en = 1'b1;
            wr_data.mean = new_m;
            wr_data.weight = W_ONE;
            mean_in[span_ff] = new_m;
            span_done = 1'b1;
         end
         B_PUSH: begin
            out_push = 1'b1;
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (span_done) begin
         if (span_ff == SPAN_W'(SPAN_COUNT - 1)) begin
            state_in = B_PUSH;
         end else begin
            span_in = SPAN_W'(span_ff + SPAN_W'(1));
            addr_in = ADDR_W'(addr_ff + ADDR_W'(1));
            state_in = B_READ;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_SPANS; k++) begin
         mean_full[k] = '0;
      end
      for (int k = 0; k < SPAN_COUNT; k++) begin
         mean_full[k] = mean_ff[k];
      end
      out_item.sig_num = cur_ff.index;
      out_item.raw_value = cur_ff.valid ? cur_ff.value : '0;
      out_item.mean_span0 = mean_full[0];
      out_item.mean_span1 = mean_full[1];
      out_item.mean_span2 = mean_full[2];
      out_item.mean_span3 = mean_full[3];
      out_item.last_of_sample = (cur_ff.index == SIG_SPEED_POWER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         started_ff <= '0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      span_ff <= span_in;
      addr_ff <= addr_in;
      w_ff <= w_in;
      q_ff <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      m_ff <= m_in;
      d_ff <= d_in;
      up_ff <= up_in;
      cnt_ff <= cnt_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      mean_ff <= mean_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[addr_ff] <= wr_data;
      end
      rd_ff <= state_mem[addr_ff];
   end

endmodule

[hw/rtl/mfe_checker.sv]
`timescale 1ns / 1ps
module mfe_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input logic                  empty,
   input logic                  pop,
   input mfe_pkg::rsp_item_type rsp_item
);
   import mfe_pkg::*;

   assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.last_of_sample == (rsp_item.sig_num == SIG_SPEED_POWER)))
      else $error("last flag does not match signal index");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.sig_num <= SIG_SPEED_POWER))
      else $error("signal index out of range");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting item changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("input side not busy after accepting an item");

endmodule

bind motor_feature_ewma_bank_core mfe_checker u_mfe_checker (.*);

[sim/tb_motor_feature_ewma_bank_core.sv]
`timescale 1ns / 1ps
module tb_motor_feature_ewma_bank_core;
   import mfe_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SPAN0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SPAN1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SPAN2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SPAN3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST = 3'd7;
   localparam logic [5:0] MASK_ALL = 6'h3F;
   localparam logic [5:0] SIG_NEEDS [SIGNAL_COUNT] = '{
      6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h06, 6'h30, 6'h36, 6'h38, 6'h3E
   };
   localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = 2500;

   logic clock;
   logic reset;
   logic push;
   logic full;
   req_item_type req_item;
   logic empty;
   logic pop = 1'b0;
   rsp_item_type rsp_item;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   logic [31:0] alpha_now [MAX_SPANS];
   logic signed [63:0] mean_now [SIGNAL_COUNT][MAX_SPANS];
   logic [63:0] weight_now [SIGNAL_COUNT][MAX_SPANS];
   bit started_now [SIGNAL_COUNT][MAX_SPANS];
   rsp_item_type pending_rsp [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   motor_feature_ewma_bank_core u_top (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [63:0] mul_sat(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [127:0] prod;
      logic [63:0] m;
      ma = a[63] ? (64'd0 - a) : a;
      mb = b[63] ? (64'd0 - b) : b;
      prod = {64'd0, ma} * {64'd0, mb};
      prod = prod >> 32;
      m = (prod > {64'd0, INT64_MAX}) ? INT64_MAX : prod[63:0];
      return (a[63] != b[63]) ? (64'd0 - m) : m;
   endfunction

   function automatic logic signed [63:0] magnitude_q(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] ma;
      logic [63:0] mb;
      ma = a[31] ? (64'd0 - 64'(a)) : 64'(a);
      mb = b[31] ? (64'd0 - 64'(b)) : 64'(b);
      x = ma * ma + mb * mb;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res << 16;
   endfunction

   function automatic void update_mean(int s, int k, bit ok, logic signed [63:0] v);
      logic [63:0] alpha;
      logic [63:0] w;
      logic [63:0] den;
      logic [63:0] r;
      logic [63:0] d;
      logic [127:0] prod;
      logic [63:0] step;
      logic signed [63:0] m;
      alpha = {32'd0, alpha_now[k]};
      if (started_now[s][k]) begin
         w = weight_now[s][k];
         if (alpha != 0) begin
            prod = {64'd0, w} * {64'd0, (64'h1_0000_0000 - alpha)};
            w = prod[95:32];
         end
         if (ok) begin
            m = mean_now[s][k];
            den = w + alpha;
            r = (den == 0) ? 64'h1_0000_0000 : ((alpha << 32) / den);
            d = (v >= m) ? (v - m) : (m - v);
            prod = {64'd0, d} * {64'd0, r};
            step = prod[95:32];
            mean_now[s][k] = (v >= m) ? (m + step) : (m - step);
            w = 64'h1_0000_0000;
         end
         weight_now[s][k] = w;
      end else if (ok) begin
         mean_now[s][k] = v;
         weight_now[s][k] = 64'h1_0000_0000;
         started_now[s][k] = 1'b1;
      end
   endfunction

   function automatic void predict_sample(req_item_type it);
      logic signed [63:0] sig [SIGNAL_COUNT];
      logic signed [63:0] p;
      rsp_item_type r;
      bit ok;
      sig[SIG_TEMP] = 64'(it.temperature) <<< 16;
      sig[SIG_VOLT_D] = 64'(it.voltage_d) <<< 16;
      sig[SIG_VOLT_Q] = 64'(it.voltage_q) <<< 16;
      sig[SIG_SPEED] = 64'(it.speed_rpm) <<< 16;
      sig[SIG_CURR_D] = 64'(it.current_d) <<< 16;
      sig[SIG_CURR_Q] = 64'(it.current_q) <<< 16;
      sig[SIG_VOLT_MAG] = magnitude_q(it.voltage_d, it.voltage_q);
      sig[SIG_CURR_MAG] = magnitude_q(it.current_d, it.current_q);
      p = mul_sat(sig[SIG_VOLT_MAG], sig[SIG_CURR_MAG]);
      sig[SIG_POWER] = (p > $signed(INT64_MAX) - p / 2) ? $signed(INT64_MAX) : p + p / 2;
      sig[SIG_SPEED_CURR] = mul_sat(sig[SIG_SPEED], sig[SIG_CURR_MAG]);
      sig[SIG_SPEED_POWER] = mul_sat(sig[SIG_SPEED], sig[SIG_POWER]);
      for (int s = 0; s < SIGNAL_COUNT; s++) begin
         ok = (it.valid_mask & SIG_NEEDS[s]) == SIG_NEEDS[s];
         r.sig_num = 4'(s);
         r.raw_value = ok ? sig[s] : 64'sd0;
         for (int k = 0; k < MAX_SPANS; k++) update_mean(s, k, ok, sig[s]);
         r.mean_span0 = started_now[s][0] ? mean_now[s][0] : 64'sd0;
         r.mean_span1 = started_now[s][1] ? mean_now[s][1] : 64'sd0;
         r.mean_span2 = started_now[s][2] ? mean_now[s][2] : 64'sd0;
         r.mean_span3 = started_now[s][3] ? mean_now[s][3] : 64'sd0;
         r.last_of_sample = (s == SIGNAL_COUNT - 1);
         pending_rsp.push_back(r);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && pop && !empty) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", rsp_item.raw_value, 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.sig_num !== want.sig_num)
               report_mismatch("sig_num", 64'(rsp_item.sig_num), 64'(want.sig_num));
            if (rsp_item.raw_value !== want.raw_value)
               report_mismatch("raw_value", rsp_item.raw_value, want.raw_value);
            if (rsp_item.mean_span0 !== want.mean_span0)
               report_mismatch("mean_span0", rsp_item.mean_span0, want.mean_span0);
            if (rsp_item.mean_span1 !== want.mean_span1)
               report_mismatch("mean_span1", rsp_item.mean_span1, want.mean_span1);
            if (rsp_item.mean_span2 !== want.mean_span2)
               report_mismatch("mean_span2", rsp_item.mean_span2, want.mean_span2);
            if (rsp_item.mean_span3 !== want.mean_span3)
               report_mismatch("mean_span3", rsp_item.mean_span3, want.mean_span3);
            if (rsp_item.last_of_sample !== want.last_of_sample)
               report_mismatch("last_of_sample", 64'(rsp_item.last_of_sample),
                               64'(want.last_of_sample));
         end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_sample(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      predict_sample(it);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx <= CSR_ALPHA_SPAN3) alpha_now[idx] = data;
   endtask

   task automatic set_alphas(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
      wait_idle();
      csr_write(CSR_ALPHA_SPAN0, a0);
      csr_write(CSR_ALPHA_SPAN1, a1);
      csr_write(CSR_ALPHA_SPAN2, a2);
      csr_write(CSR_ALPHA_SPAN3, a3);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(2000000)) - 1000000);
         3: return 32'($signed($urandom_range(200000)) - 100000);
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type make_sample(logic [5:0] mask);
      req_item_type it;
      it.temperature = rand_value();
      it.voltage_d = rand_value();
      it.voltage_q = rand_value();
      it.speed_rpm = rand_value();
      it.current_d = rand_value();
      it.current_q = rand_value();
      it.valid_mask = mask;
      return it;
   endfunction

   function automatic req_item_type fill_sample(logic [31:0] v, logic [5:0] mask);
      req_item_type it;
      it = {v, v, v, v, v, v, mask};
      return it;
   endfunction

   task automatic test_directed();
      send_sample(fill_sample(32'd0, 6'h00));
      send_sample(fill_sample(32'h0001_0000, MASK_ALL));
      send_sample(fill_sample(32'h7FFF_FFFF, MASK_ALL));
      send_sample(fill_sample(32'h8000_0000, MASK_ALL));
      send_sample(fill_sample(32'hFFFF_FFFF, MASK_ALL));
      send_sample(fill_sample(32'h8000_0000, 6'h00));
      for (int b = 0; b < 6; b++) send_sample(make_sample(6'(1 << b)));
      for (int b = 0; b < 6; b++) send_sample(make_sample(MASK_ALL ^ 6'(1 << b)));
      send_sample(fill_sample(32'h5555_5555, MASK_ALL));
      send_sample(fill_sample(32'hAAAA_AAAA, MASK_ALL));
      send_sample(fill_sample(32'h7FFF_FFFF, 6'h00));
   endtask

   task automatic test_alpha_extremes();
      set_alphas(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h8000_0000);
      for (int i = 0; i < 6; i++) send_sample(make_sample(i % 3 == 1 ? 6'h00 : MASK_ALL));
      set_alphas(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      for (int i = 0; i < 6; i++) send_sample(make_sample(i % 2 ? 6'h00 : MASK_ALL));
      wait_idle();
      for (int i = int'(CSR_UNUSED_FIRST); i <= int'(CSR_UNUSED_LAST); i++) begin
         csr_write(CSR_INDEX_W'(i), $urandom);
      end
      for (int i = 0; i < 4; i++) send_sample(make_sample(MASK_ALL));
   endtask

   task automatic test_random_phases();
      int idle_mode [4] = '{0, 86, 0, 7};
      int stall_mode [4] = '{0, 0, 86, 7};
      for (int ph = 0; ph < 8; ph++) begin
         set_alphas($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'h00FF_FFFF),
                    $urandom_range(1, 32'h000F_FFFF), ph == 7 ? 32'hFFFF_FFFF : $urandom);
         send_idle_pct = idle_mode[ph % 4];
         recv_stall_pct = stall_mode[ph % 4];
         for (int i = 0; i < 38; i++)
            send_sample(make_sample($urandom_range(9) < 7 ? MASK_ALL : 6'($urandom)));
      end
   endtask

   initial begin
      for (int k = 0; k < MAX_SPANS; k++) alpha_now[k] = ALPHA_RESET[k];
      for (int s = 0; s < SIGNAL_COUNT; s++)
         for (int k = 0; k < MAX_SPANS; k++) begin
            mean_now[s][k] = 0;
            weight_now[s][k] = 0;
            started_now[s][k] = 1'b0;
         end
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_alpha_extremes();
      test_random_phases();
      wait_idle();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
